### src/sorted_list_insert_delete_defines.svh
// Assertion macros for the sorted list checker
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sli_pkg.sv
// Shared types, constants and codes for the sorted list
package sli_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  typedef struct packed {
    logic do_ins;
    logic do_del;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic hit;
  } cell_flag_t;

endpackage

### src/sli_cell.sv
// One list cell: holds an entry, compares it with the broadcast value, shifts
module sli_cell (
  input  logic               clk,
  input  sli_pkg::cell_ctl_t ctl,
  input  sli_pkg::data_t     val,
  input  logic               live,
  input  logic               sel,
  input  logic               left_lt,
  input  sli_pkg::data_t     left_entry,
  input  sli_pkg::data_t     right_entry,
  output sli_pkg::cell_flag_t flag,
  output sli_pkg::data_t     entry,
  output sli_pkg::data_t     rd
);
  import sli_pkg::*;

  data_t entry_r;
  data_t entry_nxt;
  logic  lt;
  logic  eq;

  assign lt       = live && ($signed(entry_r) < $signed(val));
  assign eq       = live && (entry_r == val);
  assign flag.lt  = lt;
  assign flag.hit = eq && !lt && left_lt;
  assign entry    = entry_r;
  assign rd       = (sel && live) ? entry_r : '0;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_ins && !lt) begin
      entry_nxt = left_lt ? val : left_entry;
    end else if (ctl.do_del && !lt && live) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### src/sorted_list_insert_delete.sv
// Top level of the sorted list: a row of compare-and-shift cells
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   in      | input     | in_valid, in_stall, in_func, in_value, in_position
//   out     | output    | out_valid, out_stall, out_status, out_read_value,
//           |           | out_where, out_count
//
// One item per cycle while the output is not stalled; each item gives one result in the cycle after acceptance.
// Every cell compares its entry with the item's value in the same cycle and
// shifts toward its neighbor on insert or delete; no walk over the list.
// Reset (rst_n low, synchronous) empties the list and drops the output item.
// A stalled output item holds and stalls the input side in the same cycle.
module sorted_list_insert_delete (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic signed [31:0] in_value,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_read_value,
  output logic [5:0]  out_where,
  output logic [6:0]  out_count
);
  import sli_pkg::*;

  cnt_t       count_r, count_nxt;
  logic       out_valid_r;
  status_t    status_r, status_nxt;
  logic [31:0] rdval_r, rdval_nxt;
  logic [5:0] where_r, where_nxt;

  logic       accept;
  func_t      func;
  data_t      val;
  logic       full;
  logic       found;
  logic       pos_ok;
  cell_ctl_t  ctl;
  idx_t       hit_idx;
  data_t      rd_any;

  cell_flag_t flags   [CAPACITY];
  data_t      entries [CAPACITY];
  data_t      rds     [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign func     = func_t'(in_func);
  assign val      = DATA_WIDTH'($unsigned(in_value));
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign pos_ok   = (32'(in_position) < 32'(count_r));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  live;
    logic  sel;
    logic  left_lt;
    data_t left_entry;
    data_t right_entry;

    assign live = (32'(i) < 32'(count_r));
    assign sel  = (32'(in_position) == 32'(i));

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = val;
    end else begin : g_inner
      assign left_lt    = flags[i-1].lt;
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    sli_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .val         (val),
      .live        (live),
      .sel         (sel),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .flag        (flags[i]),
      .entry       (entries[i]),
      .rd          (rds[i])
    );
  end

  always_comb begin
    hit_idx = '0;
    found   = 1'b0;
    rd_any  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found  = found | flags[i].hit;
      rd_any = rd_any | rds[i];
      if ((!flags[i].lt) && ((i == 0) || flags[(i > 0) ? i - 1 : 0].lt)) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rdval_nxt  = '0;
    where_nxt  = '0;
    unique case (func)
      FN_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.do_ins = accept;
          count_nxt  = count_r + CNT_W'(1);
          where_nxt  = 6'(hit_idx);
        end
      end
      FN_DELETE: begin
        if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          ctl.do_del = accept;
          count_nxt  = count_r - CNT_W'(1);
          where_nxt  = 6'(hit_idx);
        end
      end
      FN_READ: begin
        if (!pos_ok) begin
          status_nxt = ST_BEYOND;
        end else begin
          rdval_nxt = 32'($signed(rd_any));
          where_nxt = in_position;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
      where_r  <= where_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rdval_r;
  assign out_where      = where_r;
  assign out_count      = 7'(count_r);

endmodule

### src/sli_checker.sv
// Port-level checks for the sorted list, bound to the top level
`include "sorted_list_insert_delete_defines.svh"

module sli_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_func,
  input logic [5:0]  in_position,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_read_value,
  input logic [5:0]  out_where,
  input logic [6:0]  out_count
);
  import sli_pkg::*;

  `SLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_count), "stalled output item changed")
  `SLI_ASSERT_NOW(a_full_count, out_valid && (out_status == ST_FULL), out_count == 7'(CAPACITY), "full status with list not full")
  `SLI_ASSERT_NOW(a_err_where, out_valid && (out_status != ST_OK), (out_where == '0) && (out_read_value == '0), "error item carries position or data")
  `SLI_ASSERT_NEXT(a_read_where, in_valid && !in_stall && (in_func == FN_READ), out_valid && (({1'b0, $past(in_position)} < out_count) ? ((out_status == ST_OK) && (out_where == $past(in_position))) : (out_status == ST_BEYOND)), "read item position or status wrong")

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .in_position    (in_position),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_value (out_read_value),
  .out_where      (out_where),
  .out_count      (out_count)
);
